/* hw/rtl/sactl_pkg.sv */
// Shared constants and types of the cache tag and LRU controller.
// Depends on nothing; every other file refers to it by scoped names.
package sactl_pkg;

	localparam int ADDR_BITS  = 32;
	localparam int SETS       = 64;
	localparam int WAYS       = 4;
	localparam int LINE_BYTES = 16;

	localparam int OFF_W = $clog2(LINE_BYTES);
	localparam int IDX_W = $clog2(SETS);
	localparam int TAG_W = ADDR_BITS - OFF_W - IDX_W;
	localparam int WAY_W = 2;
	localparam int AGE_W = 2;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_WRITE_BACK  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_WRITE_ALLOC = CFG_IDX_W'(1);

	localparam logic KIND_READ  = 1'b0;
	localparam logic KIND_WRITE = 1'b1;

	typedef struct packed {
		logic             dirty;
		logic [AGE_W-1:0] age;
		logic [TAG_W-1:0] tag;
	} way_t;

	typedef way_t [WAYS-1:0] row_t;

endpackage

/* hw/rtl/sactl_if.sv */
// Channel interfaces of the cache tag and LRU controller: access requests,
// lookup results and register writes. Depends on sactl_pkg.
interface sactl_req_if;
	logic                          valid;
	logic                          ready;
	logic                          kind;
	logic [sactl_pkg::ADDR_BITS-1:0] address;

	modport source (output valid, output kind, output address, input ready);
	modport sink (input valid, input kind, input address, output ready);
endinterface

interface sactl_rsp_if;
	logic                        valid;
	logic                        ready;
	logic                        hit;
	logic [sactl_pkg::WAY_W-1:0] way_used;
	logic                        evicted;
	logic                        memory_write;

	modport source (output valid, output hit, output way_used, output evicted,
		output memory_write, input ready);
	modport sink (input valid, input hit, input way_used, input evicted,
		input memory_write, output ready);
endinterface

interface sactl_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [sactl_pkg::CFG_IDX_W-1:0]  index;
	logic [sactl_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/set_assoc_cache_tag_lru_controller.sv */
// Top level of the set-associative cache tag and true-LRU engine.
// Depends on sactl_pkg and the interfaces in sactl_if.
//
//   channel  role    payload                                    transaction when
//   req      sink    kind, address                              req.valid & req.ready
//   rsp      source  hit, way_used, evicted, memory_write       rsp.valid & rsp.ready
//   cfg      sink    index, data (bit 0 used)                   cfg.valid & cfg.ready
//
// An accepted access reads the set row from the tag RAM into stage one; when it
// completes, it writes the updated row back and loads the result register.
// A new access is taken only after the previous one has written its row back, as set
// by the read-modify-write of the single-port row memory. Reset clears the valid bits,
// the busy flag and the result valid flag; tags, ages and dirty bits need no clearing. A stalled result
// holds the finished access in stage one; the next access is taken once it moves.
module set_assoc_cache_tag_lru_controller (
	input logic          clk,
	input logic          arst_n,
	sactl_req_if.sink    req,
	sactl_rsp_if.source  rsp,
	sactl_cfg_if.sink    cfg
);

	logic wb_q;
	logic wa_q;

	sactl_pkg::row_t row_mem [sactl_pkg::SETS];

	logic [sactl_pkg::SETS-1:0][sactl_pkg::WAYS-1:0] vld_q;

	logic                            busy_s1;
	logic                            kind_s1;
	logic [sactl_pkg::TAG_W-1:0]     tag_s1;
	logic [sactl_pkg::IDX_W-1:0]     set_s1;
	sactl_pkg::row_t                 rd_s1;

	logic                            out_valid_q;
	logic                            hit_q;
	logic [sactl_pkg::WAY_W-1:0]     way_q;
	logic                            evicted_q;
	logic                            mem_q;

	logic                            acc;
	logic                            done;
	logic [sactl_pkg::IDX_W-1:0]     in_set;
	logic [sactl_pkg::TAG_W-1:0]     in_tag;

	logic [sactl_pkg::WAYS-1:0]      vset;
	logic [sactl_pkg::WAYS-1:0]      new_vld;
	sactl_pkg::row_t                 new_row;
	logic                            found;
	logic                            free;
	logic                            alloc;
	logic [sactl_pkg::WAY_W-1:0]     hit_way;
	logic [sactl_pkg::WAY_W-1:0]     free_way;
	logic [sactl_pkg::WAY_W-1:0]     old_way;
	logic [sactl_pkg::AGE_W-1:0]     old_age;
	logic [sactl_pkg::WAY_W-1:0]     sel_way;
	logic [sactl_pkg::AGE_W:0]       limit;
	logic                            is_wr;
	logic                            res_hit;
	logic [sactl_pkg::WAY_W-1:0]     res_way;
	logic                            res_evicted;
	logic                            res_mem;

	assign cfg.ready = 1'b1;
	assign req.ready = !busy_s1;
	assign acc       = req.valid && !busy_s1;
	assign done      = busy_s1 && (!out_valid_q || rsp.ready);
	assign in_set    = req.address[sactl_pkg::OFF_W +: sactl_pkg::IDX_W];
	assign in_tag    = req.address[sactl_pkg::OFF_W + sactl_pkg::IDX_W +: sactl_pkg::TAG_W];

	assign rsp.valid        = out_valid_q;
	assign rsp.hit          = hit_q;
	assign rsp.way_used     = way_q;
	assign rsp.evicted      = evicted_q;
	assign rsp.memory_write = mem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wb_q <= 1'b1;
			wa_q <= 1'b1;
		end else if (cfg.valid) begin
			case (cfg.index)
				sactl_pkg::CFG_WRITE_BACK: begin
					wb_q <= cfg.data[0];
				end
				sactl_pkg::CFG_WRITE_ALLOC: begin
					wa_q <= cfg.data[0];
				end
				default: begin
				end
			endcase
		end
	end

	// Row memory: read on accept, write back when the access completes.
	always_ff @(posedge clk) begin
		if (acc) begin
			rd_s1 <= row_mem[in_set];
		end
		if (done) begin
			row_mem[set_s1] <= new_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
		end else if (acc) begin
			busy_s1 <= 1'b1;
		end else if (done) begin
			busy_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			kind_s1 <= req.kind;
			tag_s1  <= in_tag;
			set_s1  <= in_set;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (done) begin
			vld_q[set_s1] <= new_vld;
		end
	end

	always_comb begin
		vset     = vld_q[set_s1];
		is_wr    = (kind_s1 == sactl_pkg::KIND_WRITE);
		found    = 1'b0;
		hit_way  = '0;
		free     = 1'b0;
		free_way = '0;
		// scan high to low so the lowest matching way wins
		for (int w = sactl_pkg::WAYS - 1; w >= 0; w--) begin
			if (vset[w] && rd_s1[w].tag == tag_s1) begin
				found   = 1'b1;
				hit_way = sactl_pkg::WAY_W'(w);
			end
			if (!vset[w]) begin
				free     = 1'b1;
				free_way = sactl_pkg::WAY_W'(w);
			end
		end
		old_age = '0;
		old_way = '0;
		for (int w = 0; w < sactl_pkg::WAYS; w++) begin
			if (rd_s1[w].age > old_age) begin
				old_age = rd_s1[w].age;
				old_way = sactl_pkg::WAY_W'(w);
			end
		end

		alloc   = !found && !(is_wr && !wa_q);
		sel_way = found ? hit_way : (free ? free_way : old_way);
		if (found || !free) begin
			limit = {1'b0, rd_s1[sel_way].age};
		end else begin
			limit = (sactl_pkg::AGE_W + 1)'(sactl_pkg::WAYS);
		end

		new_row = rd_s1;
		new_vld = vset;
		if (found || alloc) begin
			for (int w = 0; w < sactl_pkg::WAYS; w++) begin
				if (sactl_pkg::WAY_W'(w) != sel_way && vset[w]
						&& {1'b0, rd_s1[w].age} < limit
						&& rd_s1[w].age < sactl_pkg::AGE_W'(sactl_pkg::WAYS - 1)) begin
					new_row[w].age = rd_s1[w].age + 1'b1;
				end
			end
			new_row[sel_way].age = '0;
		end
		if (found && is_wr && wb_q) begin
			new_row[sel_way].dirty = 1'b1;
		end
		if (alloc) begin
			new_row[sel_way].tag   = tag_s1;
			new_row[sel_way].dirty = is_wr && wb_q;
			new_vld[sel_way]       = 1'b1;
		end

		res_hit     = found;
		res_way     = (found || alloc) ? sel_way : '0;
		res_evicted = alloc && !free;
		if (found) begin
			res_mem = is_wr && !wb_q;
		end else if (!alloc) begin
			res_mem = 1'b1;
		end else begin
			res_mem = (!free && rd_s1[sel_way].dirty) || (is_wr && !wb_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			hit_q     <= res_hit;
			way_q     <= res_way;
			evicted_q <= res_evicted;
			mem_q     <= res_mem;
		end
	end

endmodule

/* hw/rtl/sactl_checker.sv */
// Port-level checks of the cache tag and LRU controller, bound to the top level.
// Depends on sactl_pkg for field widths.
module sactl_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic                          rsp_hit,
	input logic [sactl_pkg::WAY_W-1:0]   rsp_way_used,
	input logic                          rsp_evicted,
	input logic                          rsp_memory_write
);

	// one access at a time: no transaction right after an accepted one
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while an access is in flight");

	// with the result slot free, the answer shows once the access has passed stage one into the result register
	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (!rsp_valid || rsp_ready) |=> ##1 rsp_valid)
		else $error("result missing after an access");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp_hit && rsp_evicted))
		else $error("hit reported together with an eviction");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit)
			&& $stable(rsp_way_used) && $stable(rsp_evicted) && $stable(rsp_memory_write))
		else $error("stalled result changed");

endmodule

bind set_assoc_cache_tag_lru_controller sactl_checker u_sactl_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_hit          (rsp.hit),
	.rsp_way_used     (rsp.way_used),
	.rsp_evicted      (rsp.evicted),
	.rsp_memory_write (rsp.memory_write)
);
